/* src/ray_box_slab_test_unit_assert.svh */
// assertion macros for the ray box slab test unit
// standalone header, no dependencies; expects clock and reset in the using module
`ifndef RAY_BOX_SLAB_TEST_UNIT_ASSERT_SVH
`define RAY_BOX_SLAB_TEST_UNIT_ASSERT_SVH

// same-cycle implication
`define RBST_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RBST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/rbst_pkg.sv */
// shared types and constants for the ray box slab test unit
// no dependencies
package rbst_pkg;

   localparam int COORD_BITS = 32;
   localparam int FRAC_BITS  = 16;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = DIFF_BITS + COORD_BITS;
   localparam int CSR_INDEX_BITS = 3;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BOX_MIN_X = 3'd0,
      CSR_BOX_MIN_Y = 3'd1,
      CSR_BOX_MIN_Z = 3'd2,
      CSR_BOX_MAX_X = 3'd3,
      CSR_BOX_MAX_Y = 3'd4,
      CSR_BOX_MAX_Z = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] origin_x;
      logic signed [COORD_BITS-1:0] origin_y;
      logic signed [COORD_BITS-1:0] origin_z;
      logic signed [COORD_BITS-1:0] inv_dir_x;
      logic signed [COORD_BITS-1:0] inv_dir_y;
      logic signed [COORD_BITS-1:0] inv_dir_z;
   } req_type;

   typedef struct packed {
      logic                         hit;
      logic signed [COORD_BITS-1:0] t_near;
      logic signed [COORD_BITS-1:0] t_far;
   } rsp_type;

endpackage

/* src/ray_box_slab_test_unit.sv */
// throughput: one item per cycle while rsp_stall is low; the six signed multipliers sit in their own stage
// stages: input register, product register, result register; empty stages fill under stall
// reset: synchronous, clears all valid flags and loads the box with an empty box
// (lower corner at the largest value, upper corner at the most negative value)
`include "ray_box_slab_test_unit_assert.svh"

module ray_box_slab_test_unit
   import rbst_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  coord_type                 csr_data
);

   coord_type box_min_x_ff, box_min_y_ff, box_min_z_ff;
   coord_type box_max_x_ff, box_max_y_ff, box_max_z_ff;

   logic    in_valid_ff, in_valid_in;
   logic    prod_valid_ff, prod_valid_in;
   logic    rsp_valid_ff, rsp_valid_in;
   req_type in_data_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   logic out_free, prod_free, in_free;
   logic adv_in, adv_prod, adv_out;

   coord_type near_x, near_y, near_z;
   coord_type far_x, far_y, far_z;
   coord_type near_xy, far_xy, near_max, far_min;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_min_x_ff <= COORD_MAX;
         box_min_y_ff <= COORD_MAX;
         box_min_z_ff <= COORD_MAX;
         box_max_x_ff <= COORD_MIN;
         box_max_y_ff <= COORD_MIN;
         box_max_z_ff <= COORD_MIN;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BOX_MIN_X: box_min_x_ff <= csr_data;
            CSR_BOX_MIN_Y: box_min_y_ff <= csr_data;
            CSR_BOX_MIN_Z: box_min_z_ff <= csr_data;
            CSR_BOX_MAX_X: box_max_x_ff <= csr_data;
            CSR_BOX_MAX_Y: box_max_y_ff <= csr_data;
            CSR_BOX_MAX_Z: box_max_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // pipeline flow control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign prod_free = !prod_valid_ff || out_free;
   assign in_free   = !in_valid_ff || prod_free;
   assign adv_out   = prod_valid_ff && out_free;
   assign adv_prod  = in_valid_ff && prod_free;
   assign adv_in    = req_valid && in_free;
   assign req_stall = !in_free;

   assign in_valid_in   = in_free ? req_valid : in_valid_ff;
   assign prod_valid_in = prod_free ? in_valid_ff : prod_valid_ff;
   assign rsp_valid_in  = out_free ? prod_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         prod_valid_ff <= prod_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_in) begin
         in_data_ff <= req_data;
      end
      if (adv_out) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // per-axis slab units
   rbst_slab u_slab_x (
      .clock     (clock),
      .advance   (adv_prod),
      .corner_lo (box_min_x_ff),
      .corner_hi (box_max_x_ff),
      .origin    (in_data_ff.origin_x),
      .inv_dir   (in_data_ff.inv_dir_x),
      .near      (near_x),
      .far       (far_x)
   );

   rbst_slab u_slab_y (
      .clock     (clock),
      .advance   (adv_prod),
      .corner_lo (box_min_y_ff),
      .corner_hi (box_max_y_ff),
      .origin    (in_data_ff.origin_y),
      .inv_dir   (in_data_ff.inv_dir_y),
      .near      (near_y),
      .far       (far_y)
   );

   rbst_slab u_slab_z (
      .clock     (clock),
      .advance   (adv_prod),
      .corner_lo (box_min_z_ff),
      .corner_hi (box_max_z_ff),
      .origin    (in_data_ff.origin_z),
      .inv_dir   (in_data_ff.inv_dir_z),
      .near      (near_z),
      .far       (far_z)
   );

   // entry is the latest near, exit the earliest far
   assign near_xy  = (near_y > near_x) ? near_y : near_x;
   assign near_max = (near_z > near_xy) ? near_z : near_xy;
   assign far_xy   = (far_y < far_x) ? far_y : far_x;
   assign far_min  = (far_z < far_xy) ? far_z : far_xy;

   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in.hit    = (far_min >= near_max);
      rsp_data_in.t_near = near_max;
      rsp_data_in.t_far  = far_min;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `RBST_ASSERT_IMPLY(a_hit_matches, rsp_valid_ff, rsp_data_ff.hit == (rsp_data_ff.t_far >= rsp_data_ff.t_near), "hit flag disagrees with t_near and t_far")
   `RBST_ASSERT_NEXT(a_out_loads, adv_out, rsp_valid_ff, "item leaving the product stage was lost")
   `RBST_ASSERT_NEXT(a_prod_holds, prod_valid_ff && !out_free, prod_valid_ff, "blocked product stage dropped its item")
   `RBST_ASSERT_IMPLY(a_stall_full, req_stall, in_valid_ff && prod_valid_ff && rsp_valid_ff, "input stalled while a stage was empty")

endmodule

/* src/rbst_slab.sv */
// one axis of the slab test: two distances, floor, saturate and order
// depends on rbst_pkg
module rbst_slab
   import rbst_pkg::*;
(
   input  logic      clock,
   input  logic      advance,
   input  coord_type corner_lo,
   input  coord_type corner_hi,
   input  coord_type origin,
   input  coord_type inv_dir,
   output coord_type near,
   output coord_type far
);

   localparam prod_type PROD_CMAX = prod_type'(COORD_MAX);
   localparam prod_type PROD_CMIN = prod_type'(COORD_MIN);

   diff_type  diff_lo, diff_hi;
   prod_type  prod_lo_in, prod_hi_in;
   prod_type  prod_lo_ff, prod_hi_ff;
   coord_type dist_lo, dist_hi;

   // floor by arithmetic shift, then clamp to the coordinate range
   function automatic coord_type floor_sat(prod_type p);
      prod_type q;
      coord_type r;
      q = p >>> FRAC_BITS;
      if (q > PROD_CMAX) begin
         r = COORD_MAX;
      end else if (q < PROD_CMIN) begin
         r = COORD_MIN;
      end else begin
         r = q[COORD_BITS-1:0];
      end
      return r;
   endfunction

   assign diff_lo    = diff_type'(corner_lo) - diff_type'(origin);
   assign diff_hi    = diff_type'(corner_hi) - diff_type'(origin);
   assign prod_lo_in = prod_type'(diff_lo) * prod_type'(inv_dir);
   assign prod_hi_in = prod_type'(diff_hi) * prod_type'(inv_dir);

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_lo_ff <= prod_lo_in;
         prod_hi_ff <= prod_hi_in;
      end
   end

   assign dist_lo = floor_sat(prod_lo_ff);
   assign dist_hi = floor_sat(prod_hi_ff);
   assign near    = (dist_lo < dist_hi) ? dist_lo : dist_hi;
   assign far     = (dist_lo < dist_hi) ? dist_hi : dist_lo;

endmodule
